// ===== hdl/npl_pkg.sv =====
`default_nettype none
package npl_pkg;

    // mode codes
    localparam logic [2:0] MODE_CLEAR = 3'd0;
    localparam logic [2:0] MODE_LOAD  = 3'd1;
    localparam logic [2:0] MODE_COUNT = 3'd2;
    localparam logic [2:0] MODE_CULL  = 3'd3;
    localparam logic [2:0] MODE_LABEL = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_SIZE_X   = 3'd0;
    localparam logic [2:0] CFG_SIZE_Y   = 3'd1;
    localparam logic [2:0] CFG_SIZE_Z   = 3'd2;
    localparam logic [2:0] CFG_CENTER_X = 3'd3;
    localparam logic [2:0] CFG_CENTER_Y = 3'd4;
    localparam logic [2:0] CFG_CENTER_Z = 3'd5;
    localparam logic [2:0] CFG_RADIUS   = 3'd6;
    localparam logic [2:0] CFG_MIN_VOX  = 3'd7;

    localparam int CFG_W = 30;
    localparam int CNT_W = 30;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [15:0] SIZE_RESET = 16'd256;
    localparam logic [8:0] REGION_BASE = 9'd2;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_MAX_DIM     = 1024;

    // memory write data select
    localparam logic [1:0] WSEL_LOAD = 2'd0;
    localparam logic [1:0] WSEL_INC  = 2'd1;
    localparam logic [1:0] WSEL_COPY = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [23:0] peak_x;
        logic signed [23:0] peak_y;
        logic signed [23:0] peak_z;
        logic [9:0]         voxel_x;
        logic [9:0]         voxel_y;
        logic [9:0]         voxel_z;
        logic               voxel_in_mask;
    } t_in;

    typedef struct packed {
        logic [8:0] region;
        logic [8:0] peak_total;
        logic       status;
    } t_out;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [CNT_W-1:0]   cnt;
    } t_entry;

    typedef struct packed {
        logic       item_ld;
        logic       setup;
        logic       best_clr;
        logic       scan;
        logic       wr_en;
        logic [1:0] wr_sel;
    } t_cmd;

    typedef struct packed {
        logic vox_out;
        logic mask;
        logic cull_off;
        logic busy;
        logic in_radius;
        logic keep;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/npl_datapath.sv =====
`default_nettype none
module npl_datapath import npl_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_DIM     = DEF_MAX_DIM,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [2:0]        i_cfg_idx,
    input  wire [CFG_W-1:0]  i_cfg_data,
    input  t_in              i_item,
    input  t_cmd             i_cmd,
    input  wire [AW-1:0]     i_rd_addr,
    input  wire [AW-1:0]     i_wr_addr,
    output t_sts             o_sts,
    output logic [AW-1:0]    o_best_idx
);

    logic [15:0]        r_size_x, r_size_y, r_size_z;
    logic signed [23:0] r_cen_x, r_cen_y, r_cen_z;
    logic [22:0]        r_radius;
    logic [CNT_W-1:0]   r_min_vox;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x  <= SIZE_RESET;
            r_size_y  <= SIZE_RESET;
            r_size_z  <= SIZE_RESET;
            r_cen_x   <= '0;
            r_cen_y   <= '0;
            r_cen_z   <= '0;
            r_radius  <= '0;
            r_min_vox <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_X:   r_size_x  <= i_cfg_data[15:0];
                CFG_SIZE_Y:   r_size_y  <= i_cfg_data[15:0];
                CFG_SIZE_Z:   r_size_z  <= i_cfg_data[15:0];
                CFG_CENTER_X: r_cen_x   <= i_cfg_data[23:0];
                CFG_CENTER_Y: r_cen_y   <= i_cfg_data[23:0];
                CFG_CENTER_Z: r_cen_z   <= i_cfg_data[23:0];
                CFG_RADIUS:   r_radius  <= i_cfg_data[22:0];
                CFG_MIN_VOX:  r_min_vox <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // item register
    t_in r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_ld) begin
            r_item <= i_item;
        end
    end

    // voxel position and squared radius, latched once per search
    logic [26:0]        px_u, py_u, pz_u;
    logic signed [28:0] r_pos_x, r_pos_y, r_pos_z;
    logic [45:0]        r_r2;
    assign px_u = ({1'b0, r_item.voxel_x} + 11'd1) * r_size_x;
    assign py_u = ({1'b0, r_item.voxel_y} + 11'd1) * r_size_y;
    assign pz_u = ({1'b0, r_item.voxel_z} + 11'd1) * r_size_z;
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_pos_x <= $signed({2'b00, px_u}) - {{5{r_cen_x[23]}}, r_cen_x};
            r_pos_y <= $signed({2'b00, py_u}) - {{5{r_cen_y[23]}}, r_cen_y};
            r_pos_z <= $signed({2'b00, pz_u}) - {{5{r_cen_z[23]}}, r_cen_z};
            r_r2    <= r_radius * r_radius;
        end
    end

    // peak table memory
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;
    t_entry wr_data;
    always_comb begin
        case (i_cmd.wr_sel)
            WSEL_LOAD: wr_data = '{x: r_item.peak_x, y: r_item.peak_y,
                                   z: r_item.peak_z, cnt: '0};
            WSEL_INC: begin
                wr_data = r_rd;
                if (r_rd.cnt != CNT_MAX) begin
                    wr_data.cnt = r_rd.cnt + 1'b1;
                end
            end
            default: wr_data = r_rd;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // distance pipeline: read, difference, square, sum and compare
    logic          r_v1, r_v2, r_v3;
    logic [AW-1:0] r_i1, r_i2, r_i3;
    logic signed [29:0] r_dx, r_dy, r_dz;
    logic signed [59:0] sq_x, sq_y, sq_z;
    logic [58:0]   r_sx, r_sy, r_sz;
    logic [59:0]   d2;
    logic [59:0]   r_best;
    logic          r_best_vld;
    logic [AW-1:0] r_best_idx;

    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;
    assign sq_z = r_dz * r_dz;
    assign d2 = {1'b0, r_sx} + {1'b0, r_sy} + {1'b0, r_sz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.best_clr) begin
                r_best_vld <= 1'b0;
            end else if (r_v3) begin
                r_best_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= i_rd_addr;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_dx <= {r_pos_x[28], r_pos_x} - {{6{r_rd.x[23]}}, r_rd.x};
        r_dy <= {r_pos_y[28], r_pos_y} - {{6{r_rd.y[23]}}, r_rd.y};
        r_dz <= {r_pos_z[28], r_pos_z} - {{6{r_rd.z[23]}}, r_rd.z};
        r_sx <= sq_x[58:0];
        r_sy <= sq_y[58:0];
        r_sz <= sq_z[58:0];
        // strict less keeps the lower index on a tie
        if (r_v3 && (!r_best_vld || d2 < r_best)) begin
            r_best     <= d2;
            r_best_idx <= r_i3;
        end
    end

    // status back to the controller
    assign o_sts.vox_out = ({3'b000, r_item.voxel_x} >= 13'(MAX_DIM)) ||
                           ({3'b000, r_item.voxel_y} >= 13'(MAX_DIM)) ||
                           ({3'b000, r_item.voxel_z} >= 13'(MAX_DIM));
    assign o_sts.mask      = r_item.voxel_in_mask;
    assign o_sts.cull_off  = (r_min_vox == '0);
    assign o_sts.busy      = r_v1 | r_v2 | r_v3;
    assign o_sts.in_radius = r_best < {14'd0, r_r2};
    assign o_sts.keep      = r_rd.cnt >= r_min_vox;
    assign o_best_idx      = r_best_idx;

endmodule
`default_nettype wire

// ===== hdl/npl_ctrl.sv =====
`default_nettype none
module npl_ctrl import npl_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  wire [2:0]     i_mode,
    input  wire           i_out_full,
    output logic          o_in_ready,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_rd_addr,
    output logic [AW-1:0] o_wr_addr,
    input  t_sts          i_sts,
    input  wire [AW-1:0]  i_best_idx,
    output logic          o_out_ld,
    output t_out          o_res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DRAIN  = 4'd3;
    localparam logic [3:0] S_RMW_RD = 4'd4;
    localparam logic [3:0] S_RMW_WR = 4'd5;
    localparam logic [3:0] S_CULL   = 4'd6;

    logic [3:0]    r_state, n_state;
    logic [2:0]    r_mode, n_mode;
    logic [CW-1:0] r_entries, n_entries;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic          r_pend, n_pend;
    logic          issue;

    assign o_in_ready = (r_state == S_IDLE) && !i_out_full;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_entries = r_entries;
        n_i       = r_i;
        n_j       = r_j;
        n_pend    = 1'b0;
        o_cmd     = '0;
        o_cmd.wr_sel = WSEL_COPY;
        o_rd_addr = r_i[AW-1:0];
        o_wr_addr = r_j[AW-1:0];
        o_out_ld  = 1'b0;
        o_res     = '0;
        issue     = 1'b0;
        case (r_state)
            // take a request
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.item_ld = 1'b1;
                    n_mode  = i_mode;
                    n_state = S_EXEC;
                end
            end
            // decode the registered request
            S_EXEC: begin
                case (r_mode)
                    MODE_CLEAR: begin
                        n_entries = '0;
                        o_out_ld  = 1'b1;
                        n_state   = S_IDLE;
                    end
                    MODE_LOAD: begin
                        if (r_entries < CW'(TABLE_DEPTH)) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WSEL_LOAD;
                            o_wr_addr    = r_entries[AW-1:0];
                            n_entries    = r_entries + 1'b1;
                        end else begin
                            o_res.status = 1'b1;
                        end
                        o_out_ld = 1'b1;
                        n_state  = S_IDLE;
                    end
                    MODE_COUNT, MODE_LABEL: begin
                        if (r_entries == '0 || i_sts.vox_out) begin
                            o_out_ld = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            o_cmd.setup    = 1'b1;
                            o_cmd.best_clr = 1'b1;
                            n_i     = '0;
                            n_state = S_SCAN;
                        end
                    end
                    MODE_CULL: begin
                        if (i_sts.cull_off || r_entries == '0) begin
                            o_out_ld = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_i     = '0;
                            n_j     = '0;
                            n_state = S_CULL;
                        end
                    end
                    default: begin
                        o_out_ld = 1'b1;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            // one table entry into the distance pipeline per cycle
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_i = r_i + 1'b1;
                if (n_i == r_entries) begin
                    n_state = S_DRAIN;
                end
            end
            // wait for the last distance, then decide
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    if (r_mode == MODE_LABEL) begin
                        if (i_sts.in_radius && i_sts.mask) begin
                            o_res.region = 9'(i_best_idx) + REGION_BASE;
                        end
                        o_out_ld = 1'b1;
                        n_state  = S_IDLE;
                    end else if (i_sts.in_radius && i_sts.mask) begin
                        n_state = S_RMW_RD;
                    end else begin
                        o_out_ld = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            // bump the winner's count
            S_RMW_RD: begin
                o_rd_addr = i_best_idx;
                n_state   = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WSEL_INC;
                o_wr_addr    = i_best_idx;
                o_out_ld     = 1'b1;
                n_state      = S_IDLE;
            end
            // compaction: read entry i, copy survivors to slot j
            S_CULL: begin
                issue  = r_i < r_entries;
                n_pend = issue;
                if (issue) begin
                    n_i = r_i + 1'b1;
                end
                if (r_pend && i_sts.keep) begin
                    o_cmd.wr_en = 1'b1;
                    n_j = r_j + 1'b1;
                end
                if (!issue && !r_pend) begin
                    n_entries = r_j;
                    o_out_ld  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_res.peak_total = 9'(n_entries);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_entries <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_entries <= n_entries;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_i    <= n_i;
        r_j    <= n_j;
    end

endmodule
`default_nettype wire

// ===== hdl/nearest_peak_region_labeler.sv =====
`default_nettype none
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------
// request   | i_in_valid / o_in_ready   | i_in_data (t_in)
// result    | o_out_valid / i_out_ready | o_out_data (t_out)
// config    | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// count and label stream one distance per cycle through the single table
// memory read port; a count update adds a read-modify-write of the winner.
// reset is synchronous, active low; the table needs no clearing pass.
// a request is taken only once the previous result has been taken.
module nearest_peak_region_labeler import npl_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_DIM     = DEF_MAX_DIM
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  t_in             i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output t_out            o_out_data,
    input  wire             i_cfg_we,
    input  wire [2:0]       i_cfg_idx,
    input  wire [CFG_W-1:0] i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] rd_addr, wr_addr, best_idx;
    logic          out_ld;
    t_out          res;
    logic          r_out_valid;
    t_out          r_out;

    npl_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .i_out_full (r_out_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .i_sts      (sts),
        .i_best_idx (best_idx),
        .o_out_ld   (out_ld),
        .o_res      (res)
    );

    npl_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_DIM(MAX_DIM)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_cmd      (cmd),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .o_sts      (sts),
        .o_best_idx (best_idx)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // no new request while a result is still held
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("request ready while result pending");

    // a result is only produced while the result register is free
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ld |-> !r_out_valid)
        else $error("result register overrun");

    // a taken request closes the input until its result is out
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while busy");

    // a dropped load never carries a region
    a_status_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |-> (o_out_data.region == 9'd0))
        else $error("full status with nonzero region");

endmodule
`default_nettype wire

// ===== sim/nearest_peak_region_labeler_tb.sv =====
`default_nettype none
module nearest_peak_region_labeler_tb;
    import npl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PEAKS = DEF_TABLE_DEPTH;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out             o_out_data;
    logic             i_cfg_we;
    logic [2:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    nearest_peak_region_labeler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // shadow of the block's registers and peak table
    logic [15:0]        size_x, size_y, size_z;
    logic signed [23:0] ctr_x, ctr_y, ctr_z;
    logic [22:0]        rad;
    logic [29:0]        min_vox;
    logic signed [23:0] pk_x [PEAKS];
    logic signed [23:0] pk_y [PEAKS];
    logic signed [23:0] pk_z [PEAKS];
    logic [29:0]        pk_cnt [PEAKS];
    int                 held;

    t_in  pending_requests[$];
    t_out expected_results[$];
    int   errors;
    bit   hold_sender;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic longint unsigned sq_dist(input longint d);
        longint unsigned a;
        a = (d < 0) ? longint'(-d) : longint'(d);
        return a * a;
    endfunction

    // nearest held peak, -1 when the table is empty; sets hit when inside radius
    function automatic int nearest_peak(input t_in r, output bit hit);
        longint px, py, pz;
        longint unsigned best, d2, r2;
        int bi;
        bi = -1;
        best = 0;
        hit = 0;
        if (held == 0) return -1;
        px = longint'((r.voxel_x + 64'd1) * size_x) - longint'(ctr_x);
        py = longint'((r.voxel_y + 64'd1) * size_y) - longint'(ctr_y);
        pz = longint'((r.voxel_z + 64'd1) * size_z) - longint'(ctr_z);
        for (int i = 0; i < held; i++) begin
            d2 = sq_dist(px - pk_x[i]) + sq_dist(py - pk_y[i]) + sq_dist(pz - pk_z[i]);
            if (bi < 0 || d2 < best) begin
                best = d2;
                bi = i;
            end
        end
        r2 = longint'(rad) * longint'(rad);
        hit = best < r2;
        return bi;
    endfunction

    // apply one request to the shadow table and return its result
    function automatic t_out predict_region(input t_in r);
        t_out o;
        bit hit;
        int bi, j;
        o = '0;
        case (r.mode)
            MODE_CLEAR: held = 0;
            MODE_LOAD: begin
                if (held < PEAKS) begin
                    pk_x[held] = r.peak_x;
                    pk_y[held] = r.peak_y;
                    pk_z[held] = r.peak_z;
                    pk_cnt[held] = '0;
                    held++;
                end else begin
                    o.status = 1'b1;
                end
            end
            MODE_COUNT: begin
                bi = nearest_peak(r, hit);
                if (bi >= 0 && hit && r.voxel_in_mask && pk_cnt[bi] != CNT_MAX)
                    pk_cnt[bi]++;
            end
            MODE_CULL: begin
                if (min_vox != 0) begin
                    j = 0;
                    for (int i = 0; i < held; i++) begin
                        if (pk_cnt[i] >= min_vox) begin
                            pk_x[j] = pk_x[i];
                            pk_y[j] = pk_y[i];
                            pk_z[j] = pk_z[i];
                            pk_cnt[j] = pk_cnt[i];
                            j++;
                        end
                    end
                    held = j;
                end
            end
            MODE_LABEL: begin
                bi = nearest_peak(r, hit);
                if (bi >= 0 && hit && r.voxel_in_mask)
                    o.region = 9'(bi) + REGION_BASE;
            end
            default: ;
        endcase
        o.peak_total = 9'(held);
        return o;
    endfunction

    // sender: bursts of requests with random gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        logic nxt_valid;
        t_in  nxt_data;
        nxt_valid = i_in_valid;
        nxt_data = i_in_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_region(pending_requests.pop_front()));
                nxt_valid = 1'b0;
                if (burst_left > 0) burst_left--;
            end
            if (!nxt_valid) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0 && !hold_sender) begin
                    nxt_valid = 1'b1;
                    nxt_data = pending_requests[0];
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data <= nxt_data;
    end

    // receiver: stalls on a rotating pattern that is redrawn now and then
    logic [15:0] stall_pat;
    int          pat_age;
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            stall_pat <= 16'hFFFF;
            pat_age <= 0;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, region", o_out_data.region, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.region !== want.region)
                        report_mismatch("region", o_out_data.region, want.region);
                    if (o_out_data.peak_total !== want.peak_total)
                        report_mismatch("peak_total", o_out_data.peak_total, want.peak_total);
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                end
            end
            if (pat_age == 200) begin
                pat_age <= 0;
                stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                i_out_ready <= 1'b1;
            end else begin
                pat_age <= pat_age + 1;
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
                i_out_ready <= stall_pat[0];
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_SIZE_X:   size_x = val[15:0];
            CFG_SIZE_Y:   size_y = val[15:0];
            CFG_SIZE_Z:   size_z = val[15:0];
            CFG_CENTER_X: ctr_x = val[23:0];
            CFG_CENTER_Y: ctr_y = val[23:0];
            CFG_CENTER_Z: ctr_z = val[23:0];
            CFG_RADIUS:   rad = val[22:0];
            default:      min_vox = val[29:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || expected_results.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in make_request(input logic [2:0] m, input int vx, input int vy,
                                         input int vz, input bit msk);
        t_in r;
        r = '0;
        r.mode = m;
        r.voxel_x = vx[9:0];
        r.voxel_y = vy[9:0];
        r.voxel_z = vz[9:0];
        r.voxel_in_mask = msk;
        return r;
    endfunction

    // peak placed on a small voxel grid so labels find it inside the radius
    function automatic t_in grid_peak();
        t_in r;
        r = make_request(MODE_LOAD, 0, 0, 0, 1'b0);
        r.peak_x = 24'(($urandom_range(0, 7) + 1) * size_x) - ctr_x + 24'($urandom_range(0, 600)) - 24'sd300;
        r.peak_y = 24'(($urandom_range(0, 7) + 1) * size_y) - ctr_y + 24'($urandom_range(0, 600)) - 24'sd300;
        r.peak_z = 24'(($urandom_range(0, 7) + 1) * size_z) - ctr_z + 24'($urandom_range(0, 600)) - 24'sd300;
        return r;
    endfunction

    function automatic t_in random_request();
        t_in r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            r = make_request(MODE_CLEAR, 0, 0, 0, 1'b0);
        end else if (pick < 18) begin
            r = grid_peak();
            if ($urandom_range(0, 4) == 0) begin
                r.peak_x = 24'($urandom);
                r.peak_y = 24'($urandom);
                r.peak_z = 24'($urandom);
            end
        end else if (pick < 23) begin
            r = make_request(MODE_CULL, 0, 0, 0, 1'b0);
        end else if (pick < 25) begin
            r = make_request(3'($urandom_range(5, 7)), int'($urandom_range(0, 1023)),
                             int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                             $urandom_range(0, 1) != 0);
            r.peak_x = 24'($urandom);
            r.peak_y = 24'($urandom);
            r.peak_z = 24'($urandom);
        end else begin
            r = make_request((pick < 62) ? MODE_COUNT : MODE_LABEL, $urandom_range(0, 7),
                             $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 5) != 0);
            if ($urandom_range(0, 9) == 0) begin
                r.voxel_x = 10'($urandom);
                r.voxel_y = 10'($urandom);
                r.voxel_z = 10'($urandom);
            end
            r.peak_x = 24'($urandom);
            r.peak_y = 24'($urandom);
            r.peak_z = 24'($urandom);
        end
        return r;
    endfunction

    task automatic random_settings(input bit extreme);
        write_reg(CFG_SIZE_X, extreme ? 30'hFFFF : 30'($urandom_range(64, 1024)));
        write_reg(CFG_SIZE_Y, extreme ? 30'h0 : 30'($urandom_range(64, 1024)));
        write_reg(CFG_SIZE_Z, 30'($urandom_range(64, 1024)));
        write_reg(CFG_CENTER_X, extreme ? 30'h800000 : 30'($urandom_range(0, 4096) - 2048));
        write_reg(CFG_CENTER_Y, extreme ? 30'h7FFFFF : 30'($urandom_range(0, 4096) - 2048));
        write_reg(CFG_CENTER_Z, 30'($urandom_range(0, 4096) - 2048));
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_RADIUS, 30'h7FFFFF);
            1:       write_reg(CFG_RADIUS, 30'h0);
            default: write_reg(CFG_RADIUS, 30'($urandom_range(64, 2048)));
        endcase
        case ($urandom_range(0, 4))
            0:       write_reg(CFG_MIN_VOX, 30'h0);
            1:       write_reg(CFG_MIN_VOX, 30'h3FFFFFFF);
            default: write_reg(CFG_MIN_VOX, 30'($urandom_range(1, 3)));
        endcase
    endtask

    initial begin
        t_in r;
        errors = 0;
        hold_sender = 0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SIZE_X;
        i_cfg_data = '0;
        size_x = SIZE_RESET; size_y = SIZE_RESET; size_z = SIZE_RESET;
        ctr_x = '0; ctr_y = '0; ctr_z = '0;
        rad = '0;
        min_vox = '0;
        held = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, ties, extreme positions, cull, unknown modes
        pending_requests.push_back(make_request(MODE_LABEL, 0, 0, 0, 1'b1));
        pending_requests.push_back(make_request(MODE_COUNT, 0, 0, 0, 1'b1));
        pending_requests.push_back(make_request(MODE_CULL, 0, 0, 0, 1'b0));
        wait_drained();
        write_reg(CFG_RADIUS, 30'h7FFFFF);
        write_reg(CFG_MIN_VOX, 30'd1);
        r = make_request(MODE_LOAD, 0, 0, 0, 1'b0);
        r.peak_x = 24'sd256; r.peak_y = 24'sd256; r.peak_z = 24'sd256;
        pending_requests.push_back(r);
        pending_requests.push_back(r);
        r.peak_x = 24'sh7FFFFF; r.peak_y = 24'sh7FFFFF; r.peak_z = 24'sh7FFFFF;
        pending_requests.push_back(r);
        r.peak_x = 24'sh800000; r.peak_y = 24'sh800000; r.peak_z = 24'sh800000;
        pending_requests.push_back(r);
        pending_requests.push_back(make_request(MODE_COUNT, 0, 0, 0, 1'b1));
        pending_requests.push_back(make_request(MODE_COUNT, 0, 0, 0, 1'b0));
        pending_requests.push_back(make_request(MODE_LABEL, 0, 0, 0, 1'b1));
        pending_requests.push_back(make_request(MODE_LABEL, 0, 0, 0, 1'b0));
        pending_requests.push_back(make_request(MODE_LABEL, 1023, 1023, 1023, 1'b1));
        pending_requests.push_back(make_request(MODE_COUNT, 1023, 1023, 1023, 1'b1));
        pending_requests.push_back(make_request(MODE_CULL, 0, 0, 0, 1'b0));
        pending_requests.push_back(make_request(MODE_LABEL, 0, 0, 0, 1'b1));
        pending_requests.push_back(make_request(3'd5, 0, 0, 0, 1'b1));
        pending_requests.push_back(make_request(3'd6, 0, 0, 0, 1'b1));
        pending_requests.push_back(make_request(3'd7, 1023, 1023, 1023, 1'b1));
        pending_requests.push_back(make_request(MODE_CLEAR, 0, 0, 0, 1'b0));
        pending_requests.push_back(make_request(MODE_LABEL, 0, 0, 0, 1'b1));
        wait_drained();

        // full table: loads past capacity, then a few lookups and a cull
        random_settings(1'b0);
        for (int i = 0; i < PEAKS + 3; i++) pending_requests.push_back(grid_peak());
        for (int i = 0; i < 6; i++) begin
            r = random_request();
            r.mode = (i % 2) ? MODE_LABEL : MODE_COUNT;
            pending_requests.push_back(r);
        end
        pending_requests.push_back(make_request(MODE_CULL, 0, 0, 0, 1'b0));
        pending_requests.push_back(make_request(MODE_CLEAR, 0, 0, 0, 1'b0));
        wait_drained();

        // random phases, settings changed between them
        for (int ph = 0; ph < 6; ph++) begin
            random_settings(ph == 3);
            pending_requests.push_back(make_request(MODE_CLEAR, 0, 0, 0, 1'b0));
            for (int i = 0; i < 35; i++) begin
                pending_requests.push_back(random_request());
                if (ph == 5 && i == 25) begin
                    // sender holds off until every result is back
                    hold_sender = 1;
                    while (expected_results.size() > 0 || i_in_valid) @(posedge i_clk);
                    hold_sender = 0;
                end
            end
            wait_drained();
        end

        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
